### hdl/oct_pkg.sv
// Shared types and constants for the one-shot compare timer.
package oct_pkg;

	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_START  = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BAD_HANDLE = 2'd1;
	localparam logic [1:0] ST_NO_TIMER   = 2'd2;

	localparam logic [31:0] MIN_TIMEOUT_NS = 32'd10000;
	localparam logic [31:0] MAX_TIMEOUT_NS = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] handle;
		logic [63:0] timeout_ns;
		logic [31:0] user_argument;
		logic        callback_given;
		logic        continuous;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] new_handle;
		logic        expired;
		logic [31:0] expired_handle;
		logic [31:0] expired_argument;
	} res_t;

	// request to the state stage; ticks carries the clamped ns until the quotient is known
	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] handle;
		logic [31:0] user_argument;
		logic        callback_given;
		logic        continuous;
		logic [31:0] ticks;
	} req_t;

endpackage

### hdl/oct_tdiv.sv
// Timeout clamp and ns-to-tick conversion pipeline (reciprocal multiply with correction).
module oct_tdiv
	import oct_pkg::*;
#(
	parameter int TICK_NS = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic req_valid,
	input  logic req_stall,
	output req_t req
);

	localparam logic [63:0] RECIP_W = 64'hFFFF_FFFF / 64'(TICK_NS);
	localparam logic [31:0] RECIP   = RECIP_W[31:0];
	localparam logic [31:0] DIV     = 32'(TICK_NS);
	localparam logic [31:0] DIV2    = 32'(2 * TICK_NS);
	localparam logic [31:0] DIV3    = 32'(3 * TICK_NS);
	localparam logic [31:0] MIN_TICKS = MIN_TIMEOUT_NS / 32'(TICK_NS);

	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic        en_s1, en_s2, en_s3, en_s4, en_s5;
	cmd_t        cmd_s1;
	req_t        req_s2, req_s3, req_s4, req_s5;
	logic [63:0] prod_s3;
	logic [31:0] q_s4, qd_s4;
	logic [31:0] ns_c, rem_c, q_fix_c;
	logic [63:0] prod_c;

	assign en_s5 = !v_s5 || !req_stall;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign cmd_stall = !en_s1;

	always_comb begin
		ns_c = (cmd_s1.timeout_ns[63:32] != 32'd0) ? MAX_TIMEOUT_NS : cmd_s1.timeout_ns[31:0];
		if (ns_c < MIN_TIMEOUT_NS) begin
			ns_c = MIN_TIMEOUT_NS;
		end
	end

	assign prod_c = 64'(req_s2.ticks) * 64'(RECIP);

	always_comb begin
		rem_c = req_s4.ticks - qd_s4;
		if (rem_c >= DIV2) begin
			q_fix_c = q_s4 + 32'd2;
		end else if (rem_c >= DIV) begin
			q_fix_c = q_s4 + 32'd1;
		end else begin
			q_fix_c = q_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= cmd_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			cmd_s1 <= cmd;
		end
		if (en_s2) begin
			req_s2 <= {cmd_s1.command, cmd_s1.handle, cmd_s1.user_argument,
				cmd_s1.callback_given, cmd_s1.continuous, ns_c};
		end
		if (en_s3) begin
			req_s3  <= req_s2;
			prod_s3 <= prod_c;
		end
		if (en_s4) begin
			req_s4 <= req_s3;
			q_s4   <= prod_s3[63:32];
			qd_s4  <= prod_s3[63:32] * DIV;
		end
		if (en_s5) begin
			req_s5 <= {req_s4.command, req_s4.handle, req_s4.user_argument,
				req_s4.callback_given, req_s4.continuous, q_fix_c};
		end
	end

	assign req_valid = v_s5;
	assign req       = req_s5;

	// estimate is never above the true quotient and at most two below
	a_est_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (qd_s4 <= req_s4.ticks) && (req_s4.ticks - qd_s4 < DIV3))
		else $error("tick quotient estimate out of range");

	a_min_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && req_s5.command == CMD_START |-> req_s5.ticks >= MIN_TICKS)
		else $error("converted timeout below clamp");

endmodule

### hdl/oct_core.sv
// Timer state, command execution and result register.
module oct_core
	import oct_pkg::*;
#(
	parameter int SEQ_BITS = 28
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int HI_W = 32 - SEQ_BITS;
	localparam logic [HI_W-1:0] HI_ONE = HI_W'(1);

	logic        en;
	logic        res_valid_q;
	res_t        res_q;
	logic [31:0] time_q, cmp_q, cur_q, arg_q;
	logic        armed_q, slot_q;

	logic [31:0] time_n, cmp_n, cur_n, arg_n, tick_c, issued_c;
	logic        armed_n, slot_n, h_ok_c;
	res_t        res_c;

	assign en        = !res_valid_q || !res_stall;
	assign req_stall = !en;

	assign tick_c   = time_q + 32'd1;
	assign h_ok_c   = req.handle[31:SEQ_BITS] == HI_ONE;
	assign issued_c = {HI_ONE, cur_q[SEQ_BITS-1:0] + SEQ_BITS'(1)};

	always_comb begin
		time_n  = time_q;
		cmp_n   = cmp_q;
		armed_n = armed_q;
		cur_n   = cur_q;
		arg_n   = arg_q;
		slot_n  = slot_q;
		res_c   = '0;
		case (req.command)
			CMD_TICK: begin
				time_n = tick_c;
				if (armed_q && tick_c == cmp_q) begin
					armed_n = 1'b0;
					cmp_n   = 32'd0;
					if (slot_q) begin
						res_c.expired          = 1'b1;
						res_c.expired_handle   = cur_q;
						res_c.expired_argument = arg_q;
					end
				end
			end
			CMD_START: begin
				res_c.new_handle = req.handle;
				if (req.continuous) begin
					res_c.status = ST_NO_TIMER;
				end else if (req.handle == 32'd0 && slot_q) begin
					res_c.status = ST_NO_TIMER;
				end else if (req.handle != 32'd0 && !h_ok_c) begin
					res_c.status = ST_BAD_HANDLE;
				end else begin
					cur_n            = issued_c;
					res_c.new_handle = issued_c;
					arg_n            = req.user_argument;
					slot_n           = req.callback_given;
					cmp_n            = time_q + req.ticks;
					armed_n          = 1'b1;
				end
			end
			CMD_DELETE: begin
				res_c.new_handle = req.handle;
				if (req.handle != 32'd0) begin
					if (!h_ok_c) begin
						res_c.status = ST_BAD_HANDLE;
					end else if (cur_q == req.handle) begin
						slot_n           = 1'b0;
						res_c.new_handle = 32'd0;
						armed_n          = 1'b0;
						cmp_n            = 32'd0;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			time_q      <= 32'd0;
			cmp_q       <= 32'd0;
			armed_q     <= 1'b0;
			cur_q       <= 32'd0;
			arg_q       <= 32'd0;
			slot_q      <= 1'b0;
		end else if (en) begin
			res_valid_q <= req_valid;
			if (req_valid) begin
				time_q  <= time_n;
				cmp_q   <= cmp_n;
				armed_q <= armed_n;
				cur_q   <= cur_n;
				arg_q   <= arg_n;
				slot_q  <= slot_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && req_valid) begin
			res_q <= res_c;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_disarm_clears: assert property (@(posedge clk) disable iff (!arst_n)
		!armed_q |-> cmp_q == 32'd0)
		else $error("compare value left set while disarmed");

	a_fire_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.expired |-> slot_q && !armed_q)
		else $error("expiry reported with inconsistent slot state");

	a_count_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		time_q != $past(time_q) |-> $past(en && req_valid && req.command == CMD_TICK))
		else $error("tick counter moved without a tick transfer");

	a_handle_form: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q == 32'd0 || cur_q[31:SEQ_BITS] == HI_ONE)
		else $error("issued handle lacks slot tag");

endmodule

### hdl/oneshot_compare_timer_with_handles_top.sv
// Top level of the single-slot one-shot compare timer.
//
//  channel  signals                          direction  transfer when
//  cmd      cmd_valid, cmd_stall, cmd        in         cmd_valid && !cmd_stall
//  res      res_valid, res_stall, res        out        res_valid && !res_stall
//
// One item per cycle is taken while cmd_stall is low; each result is offered once its item has
// passed the conversion stages and the result register, and transfers when res_stall is low.
// The input register and the ns-to-tick conversion (one 32x32 reciprocal multiply, one
// narrow multiply, correction) span five stages; timer state and the result register form a sixth.
// arst_n clears counter, compare, handle, argument, mark and all stage valids.
// A stall on res holds the result register and backs up only the stages that are full.
module oneshot_compare_timer_with_handles_top
	import oct_pkg::*;
#(
	parameter int TICK_NS  = 20,
	parameter int SEQ_BITS = 28
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	logic req_valid;
	logic req_stall;
	req_t req;

	oct_tdiv #(
		.TICK_NS(TICK_NS)
	) u_tdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req)
	);

	oct_core #(
		.SEQ_BITS(SEQ_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

endmodule

### tb/tb_top.sv
// Self-checking testbench for the single-slot one-shot compare timer with handles.
module tb_top;
	import oct_pkg::*;

	localparam int TICK_NS  = 20;
	localparam int SEQ_BITS = 28;
	localparam logic [31:0] SEQ_MASK = (32'd1 << SEQ_BITS) - 32'd1;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic clk;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	logic cmd_taken = 1'b0;
	logic calm = 1'b0;
	int err_count = 0;

	cmd_t cmd_backlog[$];
	res_t due_results[$];

	// timer state as seen from outside
	logic [31:0] tick_count = '0;
	logic [31:0] compare_at = '0;
	logic        armed = 1'b0;
	logic [31:0] live_handle = '0;
	logic [31:0] kept_arg = '0;
	logic        callback_mark = 1'b0;

	oneshot_compare_timer_with_handles_top #(
		.TICK_NS(TICK_NS),
		.SEQ_BITS(SEQ_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#4_000_000;
		$display("oneshot_compare_timer_with_handles_top regression: fail");
		$finish;
	end

	function automatic logic owned_handle(input logic [31:0] h);
		return (h >> SEQ_BITS) == 32'd1;
	endfunction

	function automatic logic [31:0] valid_handle(input logic [31:0] seq);
		return (32'd1 << SEQ_BITS) | (seq & SEQ_MASK);
	endfunction

	function automatic logic [31:0] bad_handle();
		logic [31:0] h;
		h = $urandom;
		if (h == '0 || owned_handle(h))
			h = h | 32'h8000_0000;
		return h;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic res_t advance_timer(input cmd_t c);
		res_t r;
		logic [31:0] ns;
		r = '0;
		r.status = ST_OK;
		case (c.command)
		CMD_TICK: begin
			tick_count = tick_count + 32'd1;
			if (armed && tick_count == compare_at) begin
				armed = 1'b0;
				compare_at = '0;
				if (callback_mark) begin
					r.expired = 1'b1;
					r.expired_handle = live_handle;
					r.expired_argument = kept_arg;
				end
			end
		end
		CMD_START: begin
			r.new_handle = c.handle;
			if (c.continuous)
				r.status = ST_NO_TIMER;
			else if (c.handle == '0 && callback_mark)
				r.status = ST_NO_TIMER;
			else if (c.handle != '0 && !owned_handle(c.handle))
				r.status = ST_BAD_HANDLE;
			else begin
				live_handle = valid_handle(live_handle + 32'd1);
				r.new_handle = live_handle;
				kept_arg = c.user_argument;
				callback_mark = c.callback_given;
				ns = (c.timeout_ns > 64'(MAX_TIMEOUT_NS)) ? MAX_TIMEOUT_NS : c.timeout_ns[31:0];
				if (ns < MIN_TIMEOUT_NS)
					ns = MIN_TIMEOUT_NS;
				compare_at = tick_count + ns / 32'(TICK_NS);
				armed = 1'b1;
			end
		end
		CMD_DELETE: begin
			r.new_handle = c.handle;
			if (c.handle != '0) begin
				if (!owned_handle(c.handle))
					r.status = ST_BAD_HANDLE;
				else if (c.handle == live_handle) begin
					callback_mark = 1'b0;
					r.new_handle = '0;
					armed = 1'b0;
					compare_at = '0;
				end
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			err_count++;
		end
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n && (!cmd_valid || cmd_taken)) begin
			if (cmd_backlog.size() != 0 && (calm || $urandom_range(99) >= 15)) begin
				cmd_valid <= 1'b1;
				cmd <= cmd_backlog.pop_front();
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		res_stall <= !calm && ($urandom_range(99) < 15);
	end

	// monitor: results are checked before this edge's transfer is predicted
	always @(posedge clk) begin
		res_t want;
		cmd_taken <= cmd_valid && !cmd_stall;
		if (arst_n && res_valid && !res_stall) begin
			if (due_results.size() == 0) begin
				$error("result transfer with none outstanding");
				err_count++;
			end else begin
				want = due_results.pop_front();
				check_field("status", 64'(want.status), 64'(res.status));
				check_field("new_handle", 64'(want.new_handle), 64'(res.new_handle));
				check_field("expired", 64'(want.expired), 64'(res.expired));
				check_field("expired_handle", 64'(want.expired_handle),
					64'(res.expired_handle));
				check_field("expired_argument", 64'(want.expired_argument),
					64'(res.expired_argument));
			end
		end
		if (arst_n && cmd_valid && !cmd_stall)
			due_results.push_back(advance_timer(cmd));
	end

	function automatic cmd_t any_cmd();
		cmd_t c;
		c.command = 2'($urandom_range(3));
		c.handle = $urandom_range(1) ? valid_handle($urandom) : $urandom;
		c.timeout_ns = rand64();
		c.user_argument = $urandom;
		c.callback_given = 1'($urandom_range(1));
		c.continuous = 1'($urandom_range(1));
		return c;
	endfunction

	task automatic add_tick(input int n);
		cmd_t c;
		repeat (n) begin
			c = any_cmd();
			c.command = CMD_TICK;
			cmd_backlog.push_back(c);
		end
	endtask

	task automatic add_start(input logic [31:0] h, input logic [63:0] t, input logic cb);
		cmd_t c;
		c = any_cmd();
		c.command = CMD_START;
		c.handle = h;
		c.timeout_ns = t;
		c.callback_given = cb;
		c.continuous = 1'b0;
		cmd_backlog.push_back(c);
	endtask

	task automatic add_delete(input logic [31:0] h);
		cmd_t c;
		c = any_cmd();
		c.command = CMD_DELETE;
		c.handle = h;
		cmd_backlog.push_back(c);
	endtask

	// an item that must leave the timer untouched
	task automatic add_stray(input logic [31:0] live, input logic mark);
		cmd_t c;
		c = any_cmd();
		case ($urandom_range(4))
		0: begin
			c.command = CMD_START;
			c.continuous = 1'b1;
		end
		1: begin
			c.command = CMD_START;
			c.continuous = 1'b0;
			c.handle = (mark && $urandom_range(1)) ? '0 : bad_handle();
		end
		2: begin
			c.command = CMD_DELETE;
			c.handle = bad_handle();
		end
		3: begin
			c.command = CMD_DELETE;
			c.handle = valid_handle(live + 32'($urandom_range(1000, 1)));
		end
		default: c.command = CMD_UNUSED;
		endcase
		cmd_backlog.push_back(c);
	endtask

	task automatic wait_idle();
		while (cmd_backlog.size() != 0 || cmd_valid || due_results.size() != 0)
			@(posedge clk);
	endtask

	// one burst of work, shaped by the timer state once the pipe has drained
	task automatic queue_scenario(input bit go_long);
		logic [31:0] live, h, nxt;
		logic [63:0] t;
		logic mark, cb;
		int span, n, stop;
		live = live_handle;
		mark = callback_mark;
		nxt = valid_handle(live + 32'd1);
		case (go_long ? $urandom_range(6) : $urandom_range(9, 7))
		0, 1, 2, 3, 4, 5, 6: begin
			cb = ($urandom_range(3) != 0);
			if (!mark && $urandom_range(1))
				h = '0;
			else if (live != '0 && $urandom_range(1))
				h = live;
			else
				h = valid_handle($urandom);
			t = $urandom_range(1) ? 64'($urandom_range(10000)) : 64'($urandom_range(10600, 10000));
			add_start(h, t, cb);
			span = int'(((t < 64'(MIN_TIMEOUT_NS)) ? MIN_TIMEOUT_NS : t[31:0]) / 32'(TICK_NS));
			case ($urandom_range(5))
			0: begin
				add_tick(int'($urandom_range(20, 1)));
				add_delete(nxt);
				add_tick(span);
			end
			1: begin
				add_tick(int'($urandom_range(20, 1)));
				add_start(nxt, 64'($urandom_range(10600, 9000)), !cb);
				add_tick(span + 30);
			end
			default: begin
				stop = span - 2 + $urandom_range(6);
				for (n = 0; n < stop; n++) begin
					if ($urandom_range(99) < 4)
						add_stray(nxt, cb);
					add_tick(1);
				end
			end
			endcase
			if ($urandom_range(1))
				add_start('0, rand64(), 1'b1);
		end
		7: begin
			add_start(valid_handle($urandom), $urandom_range(1) ? rand64() : 64'($urandom), 1'b1);
			add_tick(int'($urandom_range(20, 1)));
			case ($urandom_range(2))
			0: add_delete(nxt);
			1: add_delete(valid_handle($urandom));
			default: add_delete('0);
			endcase
		end
		8: repeat ($urandom_range(30, 10)) cmd_backlog.push_back(any_cmd());
		default: begin
			repeat ($urandom_range(40, 1)) begin
				if ($urandom_range(99) < 20)
					add_stray(live, mark);
				add_tick(1);
			end
		end
		endcase
	endtask

	initial begin
		cmd_t c;
		int s;
		add_tick(1);
		c = '1;
		c.command = CMD_UNUSED;
		cmd_backlog.push_back(c);
		add_delete('0);
		add_delete('1);
		c = '1;
		c.command = CMD_START;
		c.handle = '0;
		cmd_backlog.push_back(c);
		add_start('0, '0, 1'b1);
		add_start('0, 64'd20000, 1'b1);
		add_start(32'h2000_0000, 64'd20000, 1'b1);
		add_start('1, 64'd20000, 1'b1);
		add_delete(valid_handle(SEQ_MASK));
		add_start(valid_handle(SEQ_MASK), '1, 1'b0);
		add_start(valid_handle(32'd2), 64'h1_0000_0000, 1'b1);
		add_start(valid_handle(32'd0), 64'd9999, 1'b1);
		add_start(valid_handle(32'd0), 64'd10000, 1'b1);
		add_start(valid_handle(32'd0), 64'd10019, 1'b1);
		add_start(valid_handle(32'd0), 64'(MAX_TIMEOUT_NS), 1'b1);
		add_delete(valid_handle(32'd7));
		add_delete(valid_handle(32'd7));
		add_start('0, 64'd10000, 1'b0);
		add_tick(3);
		wait_idle();

		for (s = 0; s < 6; s++) begin
			calm = (s >= 3 && s < 6);
			queue_scenario(s == 1);
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("oneshot_compare_timer_with_handles_top regression: pass");
		else
			$display("oneshot_compare_timer_with_handles_top regression: fail");
		$finish;
	end

endmodule
